>>> rtl/qmmf_pkg.sv
// ----------------------------------------------------------------------------
// qmmf_pkg
// Shared types and constants of the quadrant mean-min filter.
// ----------------------------------------------------------------------------
package qmmf_pkg;

   localparam int HALF_DEF   = 32;
   localparam int WIDTH_DEF  = 1024;
   localparam int HEIGHT_DEF = 1024;

   localparam int PIX_W   = 8;
   localparam int COORD_W = 10;
   localparam int BAND_W  = 13;
   localparam int QUAD_W  = 18;
   localparam int HS_W    = 6;
   localparam int FW_W    = 11;
   localparam int FH_W    = 11;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [HS_W-1:0] HALF_RST = 6'd17;
   localparam logic [FW_W-1:0] FW_RST   = 11'd640;
   localparam logic [FH_W-1:0] FH_RST   = 11'd480;

   // register indexes, byte address is 4 times the index
   localparam logic [1:0] REG_HALF_SIZE    = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

   localparam int DIV_STEPS = QUAD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic [HS_W-1:0] half_size;
      logic [FW_W-1:0] frame_width;
      logic [FH_W-1:0] frame_height;
   } qmmf_cfg_type;

   typedef struct packed {
      logic y_zero;
      logic y_ge_h;
      logic y_ge_2h;
      logic x_zero;
      logic x_ge_h;
      logic x_ge_2h;
      logic produce;
      logic ok;
   } qmmf_flags_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_RD_A,
      B_RD_B,
      B_RD_C,
      B_QUAD,
      B_MIN,
      B_DIV,
      B_OUT
   } qmmf_state_type;

endpackage

>>> rtl/qmmf_front.sv
// ----------------------------------------------------------------------------
// qmmf_front
// Tracks the raster position, classifies each pixel and pushes it to the queue.
// ----------------------------------------------------------------------------
module qmmf_front #(
   parameter int MAX_HALF   = qmmf_pkg::HALF_DEF,
   parameter int MAX_WIDTH  = qmmf_pkg::WIDTH_DEF,
   parameter int MAX_HEIGHT = qmmf_pkg::HEIGHT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  qmmf_pkg::qmmf_cfg_type     cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [qmmf_pkg::PIX_W-1:0] req_pixel,
   input  logic                       req_frame_start,
   output logic                       push_valid,
   input  logic                       push_ready,
   output logic [8+qmmf_pkg::PIX_W+3*$clog2(MAX_WIDTH)+2*$clog2(2*MAX_HALF)
                 +2*qmmf_pkg::COORD_W+$clog2(MAX_HALF*MAX_HALF+1)-1:0] push_data
);

   localparam int HW  = $clog2(MAX_HALF+1);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int XW  = $clog2(MAX_WIDTH+1);
   localparam int YW  = $clog2(MAX_HEIGHT+1);
   localparam int SW  = $clog2(2*MAX_HALF);
   localparam int AW  = $clog2(MAX_HALF*MAX_HALF+1);
   localparam int MW  = (XW > YW) ? XW : YW;
   localparam int LW  = ((MW > HW+1) ? MW : HW+1) + 1;

   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [SW-1:0] slot_ff, slot_in;

   logic [LW-1:0] h_raw, h, h2, w_raw, w, ht_raw, ht;
   logic [LW-1:0] x_l, y_l, slot_l, smid, xh, x2h, xn, yn, sn;
   logic [HW-1:0] h_n;
   logic [2*HW-1:0] area_full;
   qmmf_pkg::qmmf_flags_type flags;
   logic accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      h_raw  = LW'(cfg.half_size);
      if (h_raw == '0) begin
         h = LW'(1);
      end else if (h_raw > LW'(MAX_HALF)) begin
         h = LW'(MAX_HALF);
      end else begin
         h = h_raw;
      end
      h2  = h << 1;
      h_n = HW'(h);
      area_full = h_n * h_n;

      w_raw = LW'(cfg.frame_width);
      if (w_raw < LW'(4)) begin
         w = LW'(4);
      end else if (w_raw > LW'(MAX_WIDTH)) begin
         w = LW'(MAX_WIDTH);
      end else begin
         w = w_raw;
      end
      ht_raw = LW'(cfg.frame_height);
      if (ht_raw < LW'(4)) begin
         ht = LW'(4);
      end else if (ht_raw > LW'(MAX_HEIGHT)) begin
         ht = LW'(MAX_HEIGHT);
      end else begin
         ht = ht_raw;
      end

      x_l    = req_frame_start ? '0 : LW'(col_ff);
      y_l    = req_frame_start ? '0 : LW'(row_ff);
      slot_l = req_frame_start ? '0 : LW'(slot_ff);

      // row y-h sits h slots ahead of row y in the ring of 2h rows
      smid = slot_l + h;
      if (smid >= h2) begin
         smid = smid - h2;
      end
      xh  = x_l - h;
      x2h = x_l - h2;

      flags.y_zero  = (y_l == '0);
      flags.y_ge_h  = (y_l >= h);
      flags.y_ge_2h = (y_l >= h2);
      flags.x_zero  = (x_l == '0);
      flags.x_ge_h  = (x_l >= h);
      flags.x_ge_2h = (x_l >= h2);
      flags.produce = flags.x_ge_h && flags.y_ge_h;
      flags.ok      = flags.x_ge_2h && flags.y_ge_2h
                      && (x_l + LW'(2) <= w) && (y_l + LW'(2) <= ht);

      push_data = {flags, req_pixel, CW'(x_l), CW'(xh), CW'(x2h), SW'(slot_l), SW'(smid),
                   qmmf_pkg::COORD_W'(xh), qmmf_pkg::COORD_W'(y_l - h), AW'(area_full)};

      xn = x_l + LW'(1);
      yn = y_l + LW'(1);
      sn = slot_l + LW'(1);
      if (xn >= w) begin
         col_in = '0;
         if (yn >= ht) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = YW'(yn);
            slot_in = (sn == h2) ? '0 : SW'(sn);
         end
      end else begin
         col_in  = XW'(xn);
         row_in  = YW'(y_l);
         slot_in = SW'(slot_l);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

endmodule

>>> rtl/qmmf_queue.sv
// ----------------------------------------------------------------------------
// qmmf_queue
// Two-entry queue that decouples the classifier from the arithmetic sequencer.
// ----------------------------------------------------------------------------
module qmmf_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] entry_ff [qmmf_pkg::QDEPTH];
   logic [qmmf_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [qmmf_pkg::QPTR_W:0]   count_ff;
   logic push, pop;

   assign push_ready = (count_ff != (qmmf_pkg::QPTR_W+1)'(qmmf_pkg::QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/qmmf_back.sv
// ----------------------------------------------------------------------------
// qmmf_back
// Sequencer that updates line store, band sums and quadrant sums, then,
// for a centre in range, divides the smallest quadrant sum by the quadrant area.
// ----------------------------------------------------------------------------
module qmmf_back #(
   parameter int MAX_HALF  = qmmf_pkg::HALF_DEF,
   parameter int MAX_WIDTH = qmmf_pkg::WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  logic [8+qmmf_pkg::PIX_W+3*$clog2(MAX_WIDTH)+2*$clog2(2*MAX_HALF)
                 +2*qmmf_pkg::COORD_W+$clog2(MAX_HALF*MAX_HALF+1)-1:0] pop_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [qmmf_pkg::PIX_W-1:0]   rsp_filtered_pixel,
   output logic [qmmf_pkg::COORD_W-1:0] rsp_centre_x,
   output logic [qmmf_pkg::COORD_W-1:0] rsp_centre_y,
   output logic                         rsp_in_range
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int SW = $clog2(2*MAX_HALF);
   localparam int AW = $clog2(MAX_HALF*MAX_HALF+1);
   localparam int DW = 8+qmmf_pkg::PIX_W+3*CW+2*SW+2*qmmf_pkg::COORD_W+AW;
   localparam int BW = qmmf_pkg::BAND_W;
   localparam int QW = qmmf_pkg::QUAD_W;
   localparam int PW = qmmf_pkg::PIX_W;

   logic [DW-1:0] item_ff;
   qmmf_pkg::qmmf_flags_type flags;
   logic [PW-1:0] pix;
   logic [CW-1:0] x_idx, xh_idx, x2h_idx;
   logic [SW-1:0] slot, smid;
   logic [qmmf_pkg::COORD_W-1:0] cx, cy;
   logic [AW-1:0] area;

   assign {flags, pix, x_idx, xh_idx, x2h_idx, slot, smid, cx, cy, area} = item_ff;

   qmmf_pkg::qmmf_state_type state_ff, state_in;

   logic [PW-1:0]   line_mem [2**(SW+CW)];
   logic [2*BW-1:0] band_mem [2**CW];
   logic [PW-1:0]   line_q_ff;
   logic [2*BW-1:0] band_q_ff;
   logic [SW+CW-1:0] line_ra;
   logic [CW-1:0]    band_ra;
   logic mem_we, load_out;

   logic [PW-1:0]   old_ff;
   logic [2*BW-1:0] bcur_ff, bnew_ff, bmid_ff;
   logic [QW-1:0]   quad_ff [4];
   logic [QW-1:0]   dvd_ff;
   logic [AW-1:0]   rem_ff;
   logic [qmmf_pkg::CNT_W-1:0] cnt_ff;
   logic [PW-1:0]   res_ff;

   logic [PW-1:0]   mid;
   logic [BW-1:0]   new_up, new_lo;
   logic [2*BW-1:0] bold;
   logic [QW-1:0]   qbase [4];
   logic [QW-1:0]   qmin;
   logic [AW:0]     trial;
   logic            ge;
   logic [QW-1:0]   dvd_next;

   logic rsp_valid_ff;
   logic [PW-1:0] rsp_pix_ff;
   logic [qmmf_pkg::COORD_W-1:0] rsp_cx_ff, rsp_cy_ff;
   logic rsp_ok_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qmmf_pkg::B_IDLE: begin
            if (pop_valid) begin
               state_in = qmmf_pkg::B_RD_A;
            end
         end
         qmmf_pkg::B_RD_A: state_in = qmmf_pkg::B_RD_B;
         qmmf_pkg::B_RD_B: state_in = qmmf_pkg::B_RD_C;
         qmmf_pkg::B_RD_C: state_in = qmmf_pkg::B_QUAD;
         qmmf_pkg::B_QUAD: state_in = qmmf_pkg::B_MIN;
         qmmf_pkg::B_MIN: begin
            priority if (!flags.produce) begin
               state_in = qmmf_pkg::B_IDLE;
            end else if (!flags.ok) begin
               state_in = qmmf_pkg::B_OUT;
            end else begin
               state_in = qmmf_pkg::B_DIV;
            end
         end
         qmmf_pkg::B_DIV: begin
            if (cnt_ff == qmmf_pkg::CNT_W'(qmmf_pkg::DIV_STEPS-1)) begin
               state_in = qmmf_pkg::B_OUT;
            end
         end
         qmmf_pkg::B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = qmmf_pkg::B_IDLE;
            end
         end
         default: state_in = qmmf_pkg::B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop_ready = (state_ff == qmmf_pkg::B_IDLE);
      mem_we    = (state_ff == qmmf_pkg::B_RD_C);
      load_out  = (state_ff == qmmf_pkg::B_OUT) && (!rsp_valid_ff || rsp_ready);
      line_ra   = (state_ff == qmmf_pkg::B_RD_A) ? {slot, x_idx} : {smid, x_idx};
      unique case (state_ff)
         qmmf_pkg::B_RD_A: band_ra = x_idx;
         qmmf_pkg::B_RD_B: band_ra = xh_idx;
         default:          band_ra = x2h_idx;
      endcase
   end

   // datapath
   always_comb begin
      mid    = flags.y_ge_h ? line_q_ff : '0;
      if (flags.y_zero) begin
         new_up = '0;
         new_lo = BW'(pix);
      end else begin
         new_up = bcur_ff[2*BW-1:BW] + BW'(mid) - BW'(old_ff);
         new_lo = bcur_ff[BW-1:0] + BW'(pix) - BW'(mid);
      end
      bold = flags.x_ge_2h ? band_q_ff : '0;
      for (int k = 0; k < 4; k++) begin
         qbase[k] = flags.x_zero ? '0 : quad_ff[k];
      end
      qmin = quad_ff[0];
      for (int k = 1; k < 4; k++) begin
         if (quad_ff[k] < qmin) begin
            qmin = quad_ff[k];
         end
      end
      // restoring divide, one quotient bit per cycle
      trial    = {rem_ff, dvd_ff[QW-1]};
      ge       = (trial >= (AW+1)'(area));
      dvd_next = {dvd_ff[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[{slot, x_idx}] <= pix;
         band_mem[x_idx]         <= {new_up, new_lo};
      end
      line_q_ff <= line_mem[line_ra];
      band_q_ff <= band_mem[band_ra];
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         item_ff <= pop_data;
      end
      unique case (state_ff)
         qmmf_pkg::B_RD_B: begin
            old_ff  <= flags.y_ge_2h ? line_q_ff : '0;
            bcur_ff <= band_q_ff;
         end
         qmmf_pkg::B_RD_C: begin
            bnew_ff <= {new_up, new_lo};
            bmid_ff <= flags.x_ge_h ? band_q_ff : '0;
         end
         qmmf_pkg::B_MIN: begin
            dvd_ff <= qmin;
            rem_ff <= '0;
            cnt_ff <= '0;
            res_ff <= '0;
         end
         qmmf_pkg::B_DIV: begin
            rem_ff <= ge ? AW'(trial - (AW+1)'(area)) : AW'(trial);
            dvd_ff <= dvd_next;
            cnt_ff <= cnt_ff + 1'b1;
            res_ff <= (|dvd_next[QW-1:PW]) ? '1 : dvd_next[PW-1:0];
         end
         default: begin
         end
      endcase
      if (load_out) begin
         rsp_pix_ff <= res_ff;
         rsp_cx_ff  <= cx;
         rsp_cy_ff  <= cy;
         rsp_ok_ff  <= flags.ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qmmf_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            quad_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == qmmf_pkg::B_QUAD) begin
            quad_ff[0] <= qbase[0] + QW'(bmid_ff[2*BW-1:BW]) - QW'(bold[2*BW-1:BW]);
            quad_ff[1] <= qbase[1] + QW'(bnew_ff[2*BW-1:BW]) - QW'(bmid_ff[2*BW-1:BW]);
            quad_ff[2] <= qbase[2] + QW'(bmid_ff[BW-1:0]) - QW'(bold[BW-1:0]);
            quad_ff[3] <= qbase[3] + QW'(bnew_ff[BW-1:0]) - QW'(bmid_ff[BW-1:0]);
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_pixel = rsp_pix_ff;
   assign rsp_centre_x       = rsp_cx_ff;
   assign rsp_centre_y       = rsp_cy_ff;
   assign rsp_in_range       = rsp_ok_ff;

   a_rise_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == qmmf_pkg::B_OUT))
      else $error("result raised outside the output step");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_pix_ff == '0)
      else $error("border result with nonzero pixel");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == qmmf_pkg::B_DIV |=>
         state_ff == qmmf_pkg::B_DIV || state_ff == qmmf_pkg::B_OUT)
      else $error("divider left early");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != qmmf_pkg::B_IDLE |-> !pop_ready)
      else $error("queue popped while busy");

endmodule

>>> rtl/quadrant_mean_min_filter_core.sv
// ----------------------------------------------------------------------------
// quadrant_mean_min_filter_core
// Minimum-of-four-quadrant-means filter over a raster stream of gray pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, frame_start on the first
// pixel of a frame. Each pixel beat gives at most one rsp_ beat: the result for
// the centre h columns left of and h rows above it, once that centre is in the
// frame. Border centres come out with in_range low and a zero pixel.
// A classifier takes one beat per cycle, while the two-entry queue has room;
// the sequencer behind it owns the line store and the band-sum memory, each with
// a read and a write port. Per pixel: reads, quadrant update, minimum; a border
// result then goes out, an in-range one first runs the 18-step restoring divider.
// The result sits in an output register, so the next pixel is taken while a
// stalled result waits; a stall of the receiver stops the sequencer at its
// output step and the queue fills, then req_ready drops.
// Reset clears the position, the queue and the output; the stores need no
// clearing since rows are written before they are read within a frame.
// Registers (csr_; the user writes them only while idle, the block does not
// enforce it): half size at 0x0, frame width at 0x4, frame height at 0x8.
// ----------------------------------------------------------------------------
module quadrant_mean_min_filter_core #(
   parameter int MAX_HALF   = qmmf_pkg::HALF_DEF,
   parameter int MAX_WIDTH  = qmmf_pkg::WIDTH_DEF,
   parameter int MAX_HEIGHT = qmmf_pkg::HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [qmmf_pkg::PIX_W-1:0]      req_pixel,
   input  logic                            req_frame_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [qmmf_pkg::PIX_W-1:0]      rsp_filtered_pixel,
   output logic [qmmf_pkg::COORD_W-1:0]    rsp_centre_x,
   output logic [qmmf_pkg::COORD_W-1:0]    rsp_centre_y,
   output logic                            rsp_in_range,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [qmmf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [qmmf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [qmmf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int DW = 8+qmmf_pkg::PIX_W+3*$clog2(MAX_WIDTH)+2*$clog2(2*MAX_HALF)
                       +2*qmmf_pkg::COORD_W+$clog2(MAX_HALF*MAX_HALF+1);

   qmmf_pkg::qmmf_cfg_type cfg_ff;
   logic [1:0] reg_idx;
   logic csr_we;
   logic push_valid, push_ready, pop_valid, pop_ready;
   logic [DW-1:0] push_data, pop_data;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_size    <= qmmf_pkg::HALF_RST;
         cfg_ff.frame_width  <= qmmf_pkg::FW_RST;
         cfg_ff.frame_height <= qmmf_pkg::FH_RST;
      end else if (csr_we) begin
         unique case (reg_idx)
            qmmf_pkg::REG_HALF_SIZE:
               cfg_ff.half_size <= csr_pwdata[qmmf_pkg::HS_W-1:0];
            qmmf_pkg::REG_FRAME_WIDTH:
               cfg_ff.frame_width <= csr_pwdata[qmmf_pkg::FW_W-1:0];
            qmmf_pkg::REG_FRAME_HEIGHT:
               cfg_ff.frame_height <= csr_pwdata[qmmf_pkg::FH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         qmmf_pkg::REG_HALF_SIZE:    csr_prdata = qmmf_pkg::CSR_DATA_W'(cfg_ff.half_size);
         qmmf_pkg::REG_FRAME_WIDTH:  csr_prdata = qmmf_pkg::CSR_DATA_W'(cfg_ff.frame_width);
         qmmf_pkg::REG_FRAME_HEIGHT: csr_prdata = qmmf_pkg::CSR_DATA_W'(cfg_ff.frame_height);
         default:                    csr_prdata = '0;
      endcase
   end

   qmmf_front #(
      .MAX_HALF   (MAX_HALF),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   qmmf_queue #(
      .DATA_W (DW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   qmmf_back #(
      .MAX_HALF  (MAX_HALF),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_pixel (rsp_filtered_pixel),
      .rsp_centre_x       (rsp_centre_x),
      .rsp_centre_y       (rsp_centre_y),
      .rsp_in_range       (rsp_in_range)
   );

endmodule
